// ===== src/htc_pkg.sv =====
package htc_pkg;

   localparam int DEFAULT_SLOTS = 256;
   localparam int WORD_W = 64;
   localparam int HASH_SHIFT = 48;
   localparam int HASH_ROUNDS = 3;

   localparam logic ACTION_LOOKUP = 1'b0;
   localparam logic ACTION_FILL = 1'b1;

   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] table_base;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] fill_value;
   } op_type;

   typedef struct packed {
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] entry;
   } slot_type;

   // t*65521 + (t >> 48) + 1, with 65521 = 2^16 - 2^4 + 1
   function automatic logic [WORD_W-1:0] hash_round(input logic [WORD_W-1:0] t);
      logic [WORD_W-1:0] hi;
      hi = t >> HASH_SHIFT;
      return (t << 16) - (t << 4) + t + hi + WORD_W'(1);
   endfunction

endpackage

// ===== src/htc_front.sv =====
module htc_front #(
   parameter int SLOTS = htc_pkg::DEFAULT_SLOTS,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   input  logic [191:0]        req_tdata,
   output logic                push_valid,
   output htc_pkg::op_type     push_op,
   output logic [IDX_W-1:0]    push_index,
   input  logic                queue_full
);

   localparam logic [2:0] STEP_ROUND_LAST = 3'(htc_pkg::HASH_ROUNDS - 1);
   localparam logic [2:0] STEP_RECIP = 3'(htc_pkg::HASH_ROUNDS);
   localparam logic [2:0] STEP_SUB = 3'(htc_pkg::HASH_ROUNDS + 1);
   localparam logic [2:0] STEP_PUSH = 3'(htc_pkg::HASH_ROUNDS + 2);
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SLOTS);
   localparam logic [16:0] SLOTS_C = 17'(SLOTS);

   logic                busy_ff, busy_in;
   logic [2:0]          step_ff, step_in;
   logic [63:0]         t_ff, t_in;
   logic [15:0]         q_ff, q_in;
   logic [16:0]         r_ff, r_in;
   htc_pkg::op_type     op_ff, op_in;
   logic [15:0]         h;
   logic [48:0]         prod;
   logic [32:0]         qs;
   logic [32:0]         diff;
   logic [16:0]         reduced;
   logic                accept;

   assign req_tready = enable && !busy_ff;
   assign accept = req_tvalid && req_tready;
   assign h = t_ff[63:48];
   assign prod = 49'(h) * 49'(RECIP);
   assign qs = 33'(q_ff) * 33'(SLOTS_C);
   assign diff = 33'(h) - qs;
   assign reduced = (r_ff >= SLOTS_C) ? (r_ff - SLOTS_C) : r_ff;

   assign push_valid = busy_ff && (step_ff == STEP_PUSH);
   assign push_op = op_ff;
   assign push_index = reduced[IDX_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      t_in = t_ff;
      q_in = q_ff;
      r_in = r_ff;
      op_in = op_ff;
      if (accept) begin
         op_in.action = req_tuser;
         op_in.table_base = req_tdata[63:0];
         op_in.key = req_tdata[127:64];
         op_in.fill_value = req_tdata[191:128];
         t_in = req_tdata[63:0] + req_tdata[127:64] + 64'd1;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff <= STEP_ROUND_LAST) begin
            t_in = htc_pkg::hash_round(t_ff);
            step_in = step_ff + 3'd1;
         end else begin
            case (step_ff)
               STEP_RECIP: begin
                  q_in = prod[47:32];
                  step_in = STEP_SUB;
               end
               STEP_SUB: begin
                  r_in = diff[16:0];
                  step_in = STEP_PUSH;
               end
               STEP_PUSH: begin
                  if (!queue_full) begin
                     busy_in = 1'b0;
                  end
               end
               default: begin
                  busy_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      t_ff <= t_in;
      q_ff <= q_in;
      r_ff <= r_in;
      op_ff <= op_in;
   end

endmodule

// ===== src/htc_queue.sv =====
module htc_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/htc_back.sv =====
module htc_back #(
   parameter int SLOTS = htc_pkg::DEFAULT_SLOTS,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   output logic                clear_done,
   input  logic                queue_empty,
   input  htc_pkg::op_type     pop_op,
   input  logic [IDX_W-1:0]    pop_index,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_tuser,
   output logic [63:0]         rsp_tdata
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_CMP = 2'd2;
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(SLOTS - 1);

   htc_pkg::slot_type   mem_ff [SLOTS];
   htc_pkg::slot_type   rd_ff;
   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   htc_pkg::op_type     cur_ff, cur_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_hit_ff, out_hit_in;
   logic [63:0]         out_value_ff, out_value_in;
   logic                out_free;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   htc_pkg::slot_type   mem_wd;

   assign clear_done = (state_ff != ST_CLEAR);
   assign out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_hit_ff;
   assign rsp_tdata = out_value_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cur_in = cur_ff;
      pop = 1'b0;
      mem_we = 1'b0;
      mem_wa = pop_index;
      mem_wd.base = pop_op.table_base;
      mem_wd.key = pop_op.key;
      mem_wd.entry = pop_op.fill_value;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_hit_in = out_hit_ff;
      out_value_in = out_value_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               mem_we = (pop_op.action == htc_pkg::ACTION_FILL);
               cur_in = pop_op;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (cur_ff.action == htc_pkg::ACTION_FILL) begin
                  out_hit_in = 1'b0;
                  out_value_in = cur_ff.fill_value;
               end else if (rd_ff.base == cur_ff.table_base && rd_ff.key == cur_ff.key) begin
                  out_hit_in = 1'b1;
                  out_value_in = rd_ff.entry;
               end else begin
                  out_hit_in = 1'b0;
                  out_value_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (pop) begin
         rd_ff <= mem_ff[pop_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff <= cur_in;
      out_hit_ff <= out_hit_in;
      out_value_ff <= out_value_in;
   end

endmodule

// ===== src/hashed_translation_cache.sv =====
// channel   dir  tuser                 tdata (lowest bit up)
// req_      in   action (0 lookup)     table_base, key, fill_value
// rsp_      out  hit                   entry_value
//
// transactions are paced by the front hash sequencer, which takes no new
// request until it is through with the last: three hash rounds, two slot
// reduction steps, the queue push with the last correction (held while the
// queue is full), then req_tready high again; back end: the slot memory is
// read into a register, then compared into the output register
// after reset the slot memory is cleared slot by slot with req_tready low
// a stalled response holds the back end; the 2-entry queue keeps the front going
module hashed_translation_cache #(
   parameter int SLOTS = htc_pkg::DEFAULT_SLOTS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,    // action
   input  logic [191:0]  req_tdata,    // table_base, key, fill_value
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic          rsp_tuser,    // hit
   output logic [63:0]   rsp_tdata     // entry_value
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int ITEM_W = $bits(htc_pkg::op_type) + IDX_W;

   logic                clear_done;
   logic                push_valid;
   htc_pkg::op_type     push_op;
   logic [IDX_W-1:0]    push_index;
   logic                queue_full;
   logic                queue_empty;
   logic                pop;
   logic [ITEM_W-1:0]   pop_data;
   htc_pkg::op_type     pop_op;
   logic [IDX_W-1:0]    pop_index;

   assign pop_op = pop_data[ITEM_W-1:IDX_W];
   assign pop_index = pop_data[IDX_W-1:0];

   htc_front #(.SLOTS(SLOTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (clear_done),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_index (push_index),
      .queue_full (queue_full)
   );

   htc_queue #(.W(ITEM_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_op, push_index}),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   htc_back #(.SLOTS(SLOTS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .clear_done  (clear_done),
      .queue_empty (queue_empty),
      .pop_op      (pop_op),
      .pop_index   (pop_index),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== src/htc_checker.sv =====
module htc_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic          rsp_tuser,
   input logic [63:0]   rsp_tdata
);

   logic [3:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff + 4'(req_xfer) - 4'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // memory clear keeps requests out right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during memory clear");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> pending_ff != 4'd0)
      else $error("response without an outstanding request");

endmodule

bind hashed_translation_cache htc_checker u_htc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
